// File: hw/rtl/cdq_pkg.sv
// Shared types and constants for the circular deque.
package cdq_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int DATA_W        = 32;
  localparam int CAP_W         = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [1:0] CMD_INS_REAR  = 2'd0;
  localparam logic [1:0] CMD_INS_FRONT = 2'd1;
  localparam logic [1:0] CMD_DEL_REAR  = 2'd2;
  localparam logic [1:0] CMD_DEL_FRONT = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [DATA_W-1:0] value;
  } cdq_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic                     is_empty;
    logic                     is_full;
  } cdq_out_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cdq_cmd_t;

endpackage

// File: hw/rtl/circular_deque.sv
// Top level of the circular deque.
// A double-ended queue of signed 32-bit words in a circular slot memory of DEPTH
// entries; the capacity register selects how many slots are in use (clamped to
// 1..DEPTH) and writing it empties the deque. Each item is one command: insert at
// rear or front, or delete from rear or front, and yields one result with status,
// removed word and the empty and full flags after the command. The controller steps
// each item through an accept state, a state that updates the indices and accesses
// the slot memory through its registered read port, and a result state; the result
// is held while the output stalls, and the next item can be accepted in the cycle
// after the result is taken.
module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  cdq_in_t          in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output cdq_out_t         out_item,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_item    (out_item)
  );

endmodule

// File: hw/rtl/cdq_ctrl.sv
// Controller state machine that sequences one deque command at a time.
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output cdq_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_RESP);
  assign cmd.load  = in_valid && (state == S_IDLE);
  assign cmd.exec  = (state == S_EXEC);

`ifndef SYNTHESIS
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_EXEC))
    else $error("accepted item did not start execution");
  a_exec_resp: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> out_valid)
    else $error("execution did not produce a result");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input taken while a result is pending");
`endif

endmodule

// File: hw/rtl/cdq_dp.sv
// Datapath of the deque: slot memory, indices, capacity and result register.
module cdq_dp
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
)
(
  input  logic             clk,
  input  logic             rst,
  input  cdq_cmd_t         cmd,
  input  cdq_in_t          in_item,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  output cdq_out_t         out_item
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = (IW + 1 > CAP_W) ? IW + 1 : CAP_W;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [CW-1:0]     cap;
  logic [IW-1:0]     cap_m1;
  logic [IW-1:0]     head;
  logic [IW-1:0]     tail;
  logic              empty_flag;
  logic [1:0]        cmd_r;
  logic [DATA_W-1:0] val_r;
  logic [1:0]        status;
  logic              del_ok;
  logic              is_empty;
  logic              is_full;
  logic [DATA_W-1:0] rd_data;

  logic [IW-1:0] head_next;
  logic [IW-1:0] tail_next;
  logic          empty_next;
  logic [1:0]    status_next;
  logic          del_ok_next;
  logic          full_now;
  logic          full_next;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [CW-1:0] cfg_cap;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx,
                                             input logic [CW-1:0] c);
    logic [CW-1:0] s;
    s = CW'(idx) + CW'(1);
    return (s >= c) ? '0 : s[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] idx,
                                             input logic [IW-1:0] c_m1);
    return (idx == '0) ? c_m1 : idx - IW'(1);
  endfunction

  function automatic logic [CW-1:0] clamp_cap(input logic [CAP_W-1:0] c);
    logic [CW-1:0] e;
    e = CW'(c);
    if (e == '0) begin
      e = CW'(1);
    end else if (e > CW'(DEPTH)) begin
      e = CW'(DEPTH);
    end
    return e;
  endfunction

  assign cfg_cap  = clamp_cap(cfg_wr_data);
  assign full_now = !empty_flag && (wrap_inc(tail, cap) == head);

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    empty_next  = empty_flag;
    status_next = ST_DONE;
    del_ok_next = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    rd_en       = 1'b0;
    rd_addr     = head;
    unique case (cmd_r)
      CMD_INS_REAR, CMD_INS_FRONT: begin
        if (full_now) begin
          status_next = ST_OVERFLOW;
        end else if (empty_flag) begin
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b0;
          wr_en      = 1'b1;
          wr_addr    = '0;
        end else if (cmd_r == CMD_INS_REAR) begin
          tail_next = wrap_inc(tail, cap);
          wr_en     = 1'b1;
          wr_addr   = tail_next;
        end else begin
          head_next = wrap_dec(head, cap_m1);
          wr_en     = 1'b1;
          wr_addr   = head_next;
        end
      end
      CMD_DEL_REAR, CMD_DEL_FRONT: begin
        rd_addr = (cmd_r == CMD_DEL_REAR) ? tail : head;
        if (empty_flag) begin
          status_next = ST_UNDERFLOW;
        end else begin
          del_ok_next = 1'b1;
          rd_en       = 1'b1;
          if (head == tail) begin
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
          end else if (cmd_r == CMD_DEL_REAR) begin
            tail_next = wrap_dec(tail, cap_m1);
          end else begin
            head_next = wrap_inc(head, cap);
          end
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
    full_next = !empty_next && (wrap_inc(tail_next, cap) == head_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap        <= clamp_cap(CAP_RESET);
      cap_m1     <= IW'(clamp_cap(CAP_RESET) - CW'(1));
      head       <= '0;
      tail       <= '0;
      empty_flag <= 1'b1;
    end else if (cfg_wr_en) begin
      cap        <= cfg_cap;
      cap_m1     <= IW'(cfg_cap - CW'(1));
      head       <= '0;
      tail       <= '0;
      empty_flag <= 1'b1;
    end else if (cmd.exec) begin
      head       <= head_next;
      tail       <= tail_next;
      empty_flag <= empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_item.command;
      val_r <= in_item.value;
    end
    if (cmd.exec) begin
      status   <= status_next;
      del_ok   <= del_ok_next;
      is_empty <= empty_next;
      is_full  <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= val_r;
    end
    if (cmd.exec && rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign out_item.status   = status;
  assign out_item.data     = del_ok ? rd_data : '0;
  assign out_item.is_empty = is_empty;
  assign out_item.is_full  = is_full;

`ifndef SYNTHESIS
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    CW'(head) < cap)
    else $error("front index beyond capacity");
  a_tail_range: assert property (@(posedge clk) disable iff (rst)
    CW'(tail) < cap)
    else $error("rear index beyond capacity");
  a_empty_idx: assert property (@(posedge clk) disable iff (rst)
    empty_flag |-> (head == '0) && (tail == '0))
    else $error("empty deque with nonzero indices");
`endif

endmodule
